>>> design/ttqc_pkg.sv
package ttqc_pkg;

    // token length limit (a token is cut after MAX_TOKEN - 1 bytes), and the counter that tracks it
    localparam int MAX_TOKEN = 1024;
    localparam int LEN_W     = $clog2(MAX_TOKEN);
    localparam logic [LEN_W-1:0] CUT_LEN = LEN_W'(MAX_TOKEN - 1);

    // most results one input byte can cause
    localparam int MAX_RES = 3;
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // result kinds
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_EOT  = 2'd2
    } kind_t;

    // one result beat, without its last flag
    typedef struct packed {
        kind_t      kind;
        logic [7:0] tbyte;
        logic       quoted;
    } result_t;

    // all results of one input byte, in order from entry 0
    typedef struct packed {
        logic [CNT_W-1:0]          count;
        result_t [MAX_RES-1:0]     res;
    } step_t;

endpackage

>>> design/ttqc_parser.sv
module ttqc_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  logic [7:0]           in_byte,
    output ttqc_pkg::step_t      step
);

    typedef enum logic [2:0] {
        MODE_SKIP    = 3'd0,
        MODE_SLASH   = 3'd1,
        MODE_COMMENT = 3'd2,
        MODE_WORD    = 3'd3,
        MODE_QUOTED  = 3'd4
    } mode_t;

    mode_t                          mode_reg, mode_next;
    logic [ttqc_pkg::LEN_W-1:0]     len_reg, len_next;
    logic                           quoted_reg, quoted_next;

    // build one result; byte and quote flag are forced to zero where unused
    function automatic ttqc_pkg::result_t mk(ttqc_pkg::kind_t k, logic [7:0] b, logic q);
        ttqc_pkg::result_t r;
        r.kind   = k;
        r.tbyte  = (k == ttqc_pkg::KIND_BYTE) ? b : 8'h00;
        r.quoted = (k == ttqc_pkg::KIND_EOT) ? 1'b0 : q;
        return r;
    endfunction

    function automatic logic is_space(logic [7:0] b);
        return (b == ttqc_pkg::CH_SPACE) || (b == ttqc_pkg::CH_TAB) ||
               (b == ttqc_pkg::CH_CR) || (b == ttqc_pkg::CH_LF);
    endfunction

    // next state and results of one byte
    always_comb begin
        mode_t                          m;
        logic [ttqc_pkg::LEN_W-1:0]     ln;
        logic                           qt;
        logic [ttqc_pkg::CNT_W-1:0]     n;
        logic                           wb;
        ttqc_pkg::result_t [ttqc_pkg::MAX_RES-1:0] res;

        m   = mode_reg;
        ln  = len_reg;
        qt  = quoted_reg;
        n   = '0;
        wb  = 1'b0;
        res = '0;

        unique case (mode_reg)
            MODE_SLASH: begin
                if (in_byte == ttqc_pkg::CH_SLASH) begin
                    m = MODE_COMMENT;
                end else begin
                    // held slash opens a plain word
                    m  = MODE_WORD;
                    qt = 1'b0;
                    ln = '0;
                    res[n] = mk(ttqc_pkg::KIND_BYTE, ttqc_pkg::CH_SLASH, qt);
                    n  = n + 1'b1;
                    ln = ln + 1'b1;
                    if (ln >= ttqc_pkg::CUT_LEN) begin
                        res[n] = mk(ttqc_pkg::KIND_END, 8'h00, qt);
                        n  = n + 1'b1;
                        m  = MODE_SKIP;
                        ln = '0;
                        qt = 1'b0;
                    end
                    if (m == MODE_WORD) begin
                        wb = 1'b1;
                    end else if (in_byte == ttqc_pkg::CH_NUL) begin
                        res[n] = mk(ttqc_pkg::KIND_EOT, 8'h00, 1'b0);
                        n  = n + 1'b1;
                        m  = MODE_SKIP;
                        ln = '0;
                        qt = 1'b0;
                    end
                end
            end
            MODE_COMMENT: begin
                if (in_byte == ttqc_pkg::CH_NUL) begin
                    res[n] = mk(ttqc_pkg::KIND_EOT, 8'h00, 1'b0);
                    n  = n + 1'b1;
                    m  = MODE_SKIP;
                    ln = '0;
                    qt = 1'b0;
                end else if (in_byte == ttqc_pkg::CH_LF) begin
                    m = MODE_SKIP;
                end
            end
            MODE_WORD: begin
                wb = 1'b1;
            end
            MODE_QUOTED: begin
                if (in_byte == ttqc_pkg::CH_QUOTE) begin
                    res[n] = mk(ttqc_pkg::KIND_END, 8'h00, qt);
                    n  = n + 1'b1;
                    m  = MODE_SKIP;
                    ln = '0;
                    qt = 1'b0;
                end else if (in_byte == ttqc_pkg::CH_NUL) begin
                    res[n] = mk(ttqc_pkg::KIND_END, 8'h00, qt);
                    n  = n + 1'b1;
                    res[n] = mk(ttqc_pkg::KIND_EOT, 8'h00, 1'b0);
                    n  = n + 1'b1;
                    m  = MODE_SKIP;
                    ln = '0;
                    qt = 1'b0;
                end else begin
                    res[n] = mk(ttqc_pkg::KIND_BYTE, in_byte, qt);
                    n  = n + 1'b1;
                    ln = ln + 1'b1;
                    if (ln >= ttqc_pkg::CUT_LEN) begin
                        res[n] = mk(ttqc_pkg::KIND_END, 8'h00, qt);
                        n  = n + 1'b1;
                        m  = MODE_SKIP;
                        ln = '0;
                        qt = 1'b0;
                    end
                end
            end
            default: begin
                // skipping whitespace, also recovers from unused codes
                m = MODE_SKIP;
                if (in_byte == ttqc_pkg::CH_NUL) begin
                    res[n] = mk(ttqc_pkg::KIND_EOT, 8'h00, 1'b0);
                    n  = n + 1'b1;
                    ln = '0;
                    qt = 1'b0;
                end else if (is_space(in_byte)) begin
                    m = MODE_SKIP;
                end else if (in_byte == ttqc_pkg::CH_SLASH) begin
                    m = MODE_SLASH;
                end else if (in_byte == ttqc_pkg::CH_QUOTE) begin
                    m  = MODE_QUOTED;
                    qt = 1'b1;
                    ln = '0;
                end else begin
                    m  = MODE_WORD;
                    qt = 1'b0;
                    ln = '0;
                    res[n] = mk(ttqc_pkg::KIND_BYTE, in_byte, qt);
                    n  = n + 1'b1;
                    ln = ln + 1'b1;
                    if (ln >= ttqc_pkg::CUT_LEN) begin
                        res[n] = mk(ttqc_pkg::KIND_END, 8'h00, qt);
                        n  = n + 1'b1;
                        m  = MODE_SKIP;
                        ln = '0;
                        qt = 1'b0;
                    end
                end
            end
        endcase

        // plain word continuation
        if (wb) begin
            if (in_byte == ttqc_pkg::CH_NUL) begin
                res[n] = mk(ttqc_pkg::KIND_END, 8'h00, qt);
                n  = n + 1'b1;
                res[n] = mk(ttqc_pkg::KIND_EOT, 8'h00, 1'b0);
                n  = n + 1'b1;
                m  = MODE_SKIP;
                ln = '0;
                qt = 1'b0;
            end else if (is_space(in_byte)) begin
                res[n] = mk(ttqc_pkg::KIND_END, 8'h00, qt);
                n  = n + 1'b1;
                m  = MODE_SKIP;
                ln = '0;
                qt = 1'b0;
            end else begin
                res[n] = mk(ttqc_pkg::KIND_BYTE, in_byte, qt);
                n  = n + 1'b1;
                ln = ln + 1'b1;
                if (ln >= ttqc_pkg::CUT_LEN) begin
                    res[n] = mk(ttqc_pkg::KIND_END, 8'h00, qt);
                    n  = n + 1'b1;
                    m  = MODE_SKIP;
                    ln = '0;
                    qt = 1'b0;
                end
            end
        end

        mode_next   = m;
        len_next    = ln;
        quoted_next = qt;
        step.count  = n;
        step.res    = res;
    end

    // parser state, advanced once per accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_SKIP;
            len_reg    <= '0;
            quoted_reg <= 1'b0;
        end else if (load) begin
            mode_reg   <= mode_next;
            len_reg    <= len_next;
            quoted_reg <= quoted_next;
        end
    end

endmodule

>>> design/text_tokenizer_quotes_comments_unit.sv
// channel | ports                                               | beat
// input   | s_valid s_ready s_in_byte                           | one text byte, 0 ends text
// result  | m_valid m_ready m_out_kind m_token_byte             | one token byte, token end
//         | m_token_quoted m_run_last                           | or end of text
//
// a byte is parsed in the cycle it is accepted; its 0 to 3 results are loaded into
// a three-entry result buffer and leave one per cycle while m_ready is high, from
// the next cycle on. a new byte is taken whenever the buffer is empty or its last
// entry leaves: one byte per cycle unless m_ready is low or a byte yields 2 or 3 results.
// reset (aresetn low, synchronous) empties the buffer and returns to whitespace skip.
// a stall on the result side holds the buffer and blocks input while any result waits.
module text_tokenizer_quotes_comments_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_out_kind,
    output logic [7:0]  m_token_byte,
    output logic        m_token_quoted,
    output logic        m_run_last
);

    ttqc_pkg::step_t                 step;
    ttqc_pkg::result_t               buf_reg  [ttqc_pkg::MAX_RES];
    ttqc_pkg::result_t               buf_next [ttqc_pkg::MAX_RES];
    logic [ttqc_pkg::CNT_W-1:0]      rem_reg, rem_next;
    logic                            s_acc, m_acc;

    // handshakes
    assign m_valid = (rem_reg != '0);
    assign s_ready = (rem_reg == '0) || ((rem_reg == ttqc_pkg::CNT_W'(1)) && m_ready);
    assign s_acc   = s_valid && s_ready;
    assign m_acc   = m_valid && m_ready;

    ttqc_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (s_acc),
        .in_byte (s_in_byte),
        .step    (step)
    );

    // result buffer: shift out on a result beat, reload on an input beat
    always_comb begin
        for (int i = 0; i < ttqc_pkg::MAX_RES; i++) begin
            buf_next[i] = buf_reg[i];
        end
        rem_next = rem_reg;
        if (m_acc) begin
            for (int i = 0; i < ttqc_pkg::MAX_RES - 1; i++) begin
                buf_next[i] = buf_reg[i+1];
            end
            rem_next = rem_reg - 1'b1;
        end
        if (s_acc) begin
            for (int i = 0; i < ttqc_pkg::MAX_RES; i++) begin
                buf_next[i] = step.res[i];
            end
            rem_next = step.count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
        end else begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < ttqc_pkg::MAX_RES; i++) begin
            buf_reg[i] <= buf_next[i];
        end
    end

    // result beat outputs
    assign m_out_kind     = buf_reg[0].kind;
    assign m_token_byte   = buf_reg[0].tbyte;
    assign m_token_quoted = buf_reg[0].quoted;
    assign m_run_last     = (rem_reg == ttqc_pkg::CNT_W'(1));

    // no input while more than one result is still queued
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (rem_reg > ttqc_pkg::CNT_W'(1)) |-> !s_ready)
        else $error("input taken while result buffer busy");

    // a byte without results leaves nothing behind
    a_silent_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && (step.count == '0)) |=> !m_valid)
        else $error("result shown for a silent byte");

    // end of text is always the last result of its byte and never quoted
    a_eot_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_out_kind == ttqc_pkg::KIND_EOT)) |-> (m_run_last && !m_token_quoted))
        else $error("end of text not last or marked quoted");

    // non-byte results carry a zero byte
    a_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_out_kind != ttqc_pkg::KIND_BYTE)) |-> (m_token_byte == 8'h00))
        else $error("token byte set on a marker result");

endmodule

>>> dv/testbench.sv
module testbench;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_LEN    = 60;
    localparam int DRAIN_WAIT  = 8;

    // parser modes of the token predictor
    typedef enum logic [2:0] {
        PM_SKIP,
        PM_SLASH,
        PM_COMMENT,
        PM_WORD,
        PM_QUOTED
    } parse_mode_t;

    // one expected result beat
    typedef struct {
        ttqc_pkg::kind_t kind;
        logic [7:0]      tbyte;
        logic            quoted;
        logic            last;
    } tok_result_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_in_byte;
    logic       m_valid;
    logic       m_ready;
    logic [1:0] m_out_kind;
    logic [7:0] m_token_byte;
    logic       m_token_quoted;
    logic       m_run_last;

    // predictor state
    parse_mode_t pm_state   = PM_SKIP;
    int          tok_len    = 0;
    logic        tok_quoted = 1'b0;
    tok_result_t byte_results[$];
    tok_result_t pending_results[$];

    int mismatch_count  = 0;
    int sent_bytes      = 0;
    int send_gap_pct    = 0;
    int recv_stall_pct  = 0;
    int hold_cycles     = 0;

    text_tokenizer_quotes_comments_unit u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_kind     (m_out_kind),
        .m_token_byte   (m_token_byte),
        .m_token_quoted (m_token_quoted),
        .m_run_last     (m_run_last)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic bit is_sep(logic [7:0] b);
        return b == ttqc_pkg::CH_SPACE || b == ttqc_pkg::CH_TAB ||
               b == ttqc_pkg::CH_CR || b == ttqc_pkg::CH_LF;
    endfunction

    function automatic logic [7:0] rand_sep();
        case ($urandom_range(0, 3))
            0: return ttqc_pkg::CH_SPACE;
            1: return ttqc_pkg::CH_TAB;
            2: return ttqc_pkg::CH_CR;
            default: return ttqc_pkg::CH_LF;
        endcase
    endfunction

    // nonzero non-separator byte; a token start excludes quote and slash
    function automatic logic [7:0] rand_text(bit first);
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (is_sep(b) ||
               (first && (b == ttqc_pkg::CH_QUOTE || b == ttqc_pkg::CH_SLASH)));
        return b;
    endfunction

    function automatic logic [7:0] rand_letter();
        return 8'($urandom_range(8'h41, 8'h7A));
    endfunction

    // token predictor
    function automatic void add_result(ttqc_pkg::kind_t k, logic [7:0] b);
        tok_result_t r;
        r.kind   = k;
        r.tbyte  = (k == ttqc_pkg::KIND_BYTE) ? b : 8'h00;
        r.quoted = (k == ttqc_pkg::KIND_EOT) ? 1'b0 : tok_quoted;
        r.last   = 1'b0;
        byte_results.push_back(r);
    endfunction

    function automatic void close_token();
        add_result(ttqc_pkg::KIND_END, 8'h00);
        pm_state   = PM_SKIP;
        tok_len    = 0;
        tok_quoted = 1'b0;
    endfunction

    function automatic void close_text();
        add_result(ttqc_pkg::KIND_EOT, 8'h00);
        pm_state   = PM_SKIP;
        tok_len    = 0;
        tok_quoted = 1'b0;
    endfunction

    // token byte with forced end at the length limit
    function automatic void append_byte(logic [7:0] b);
        add_result(ttqc_pkg::KIND_BYTE, b);
        tok_len++;
        if (tok_len >= ttqc_pkg::MAX_TOKEN - 1) close_token();
    endfunction

    function automatic void continue_word(logic [7:0] b);
        if (b == ttqc_pkg::CH_NUL) begin
            close_token();
            close_text();
        end else if (is_sep(b)) begin
            close_token();
        end else begin
            append_byte(b);
        end
    endfunction

    // expected results of one text byte, queued in order
    function automatic int predict_tokens(logic [7:0] b);
        byte_results.delete();
        case (pm_state)
            PM_SLASH: begin
                if (b == ttqc_pkg::CH_SLASH) begin
                    pm_state = PM_COMMENT;
                end else begin
                    pm_state   = PM_WORD;
                    tok_quoted = 1'b0;
                    tok_len    = 0;
                    append_byte(ttqc_pkg::CH_SLASH);
                    if (pm_state == PM_WORD) continue_word(b);
                    else if (b == ttqc_pkg::CH_NUL) close_text();
                end
            end
            PM_COMMENT: begin
                if (b == ttqc_pkg::CH_NUL) close_text();
                else if (b == ttqc_pkg::CH_LF) pm_state = PM_SKIP;
            end
            PM_WORD: continue_word(b);
            PM_QUOTED: begin
                if (b == ttqc_pkg::CH_QUOTE) begin
                    close_token();
                end else if (b == ttqc_pkg::CH_NUL) begin
                    close_token();
                    close_text();
                end else begin
                    append_byte(b);
                end
            end
            default: begin
                pm_state = PM_SKIP;
                if (b == ttqc_pkg::CH_NUL) begin
                    close_text();
                end else if (!is_sep(b)) begin
                    if (b == ttqc_pkg::CH_SLASH) begin
                        pm_state = PM_SLASH;
                    end else if (b == ttqc_pkg::CH_QUOTE) begin
                        pm_state   = PM_QUOTED;
                        tok_quoted = 1'b1;
                        tok_len    = 0;
                    end else begin
                        pm_state   = PM_WORD;
                        tok_quoted = 1'b0;
                        tok_len    = 0;
                        append_byte(b);
                    end
                end
            end
        endcase
        if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last = 1'b1;
        foreach (byte_results[i]) pending_results.push_back(byte_results[i]);
        return byte_results.size();
    endfunction

    // send one text byte; called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_valid   <= 1'b0;
            s_in_byte <= 8'($urandom);
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        do @(posedge aclk); while (!s_ready);
        void'(predict_tokens(b));
        sent_bytes++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string s);
        foreach (s[i]) send_byte(s[i]);
    endtask

    // sender pauses until every expected beat has come out
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_results.size() != 0);
    endtask

    // result side readiness, with an optional long hold-off
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // result checking against the oldest expectation
    function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        tok_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: kind %0d byte %0h", m_out_kind, m_token_byte);
                mismatch_count++;
            end else begin
                e = pending_results.pop_front();
                check_field("out_kind", 8'(e.kind), 8'(m_out_kind));
                check_field("token_byte", e.tbyte, m_token_byte);
                check_field("token_quoted", 8'(e.quoted), 8'(m_token_quoted));
                check_field("run_last", 8'(e.last), 8'(m_run_last));
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    // extremes of the byte, every token form and the parser's corners short of the length cut
    task automatic test_directed();
        send_byte(ttqc_pkg::CH_NUL);
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(ttqc_pkg::CH_TAB);
        send_text("\"\"\" \"/x\"");
        send_byte(ttqc_pkg::CH_CR);
        send_text("//q");
        send_byte(ttqc_pkg::CH_LF);
        send_text("/ ");
        send_byte(ttqc_pkg::CH_SLASH);
        send_byte(ttqc_pkg::CH_NUL);
        send_text("\"z");
        send_byte(ttqc_pkg::CH_NUL);
        send_text("//");
        send_byte(ttqc_pkg::CH_NUL);
    endtask

    // random texts built mostly from well-formed tokens, with some noise
    task automatic test_random(input int n_bytes);
        int         start;
        int         pick;
        int         len;
        logic [7:0] b;
        start = sent_bytes;
        while (sent_bytes - start < n_bytes) begin
            pick = $urandom_range(0, 19);
            len  = $urandom_range(0, 7);
            if (pick < 7) begin
                send_byte(rand_text(1));
                repeat (len) send_byte(rand_text(0));
            end else if (pick < 11) begin
                send_byte(ttqc_pkg::CH_QUOTE);
                repeat (len) begin
                    do b = 8'($urandom_range(1, 255)); while (b == ttqc_pkg::CH_QUOTE);
                    send_byte(b);
                end
                if ($urandom_range(0, 7) != 0) send_byte(ttqc_pkg::CH_QUOTE);
            end else if (pick < 13) begin
                send_byte(ttqc_pkg::CH_SLASH);
                send_byte(ttqc_pkg::CH_SLASH);
                repeat (len) begin
                    do b = 8'($urandom_range(1, 255)); while (b == ttqc_pkg::CH_LF);
                    send_byte(b);
                end
                if ($urandom_range(0, 3) != 0) send_byte(ttqc_pkg::CH_LF);
            end else if (pick < 15) begin
                send_byte(ttqc_pkg::CH_SLASH);
                send_byte(8'($urandom_range(0, 255)));
            end else if (pick < 18) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 9) == 0) send_byte(ttqc_pkg::CH_NUL);
            else repeat ($urandom_range(1, 2)) send_byte(rand_sep());
        end
    endtask

    // long stall on the result side while bytes keep coming
    task automatic test_backpressure();
        hold_cycles = HOLD_LEN;
        repeat (24) send_byte(rand_letter());
        send_byte(ttqc_pkg::CH_SPACE);
        repeat (4) begin
            send_byte(ttqc_pkg::CH_SLASH);
            send_byte(ttqc_pkg::CH_NUL);
        end
    endtask

    // sender holds off until the block has emptied, then carries on
    task automatic test_drain_pause();
        send_text("\"ab");
        wait_drained();
        send_text("c\" w");
        wait_drained();
        send_byte(ttqc_pkg::CH_NUL);
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_in_byte = 8'h00;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_gap_pct   = 37;
        recv_stall_pct = 80;
        test_directed();
        test_random(60);
        test_backpressure();

        send_gap_pct   = 80;
        recv_stall_pct = 37;
        test_random(60);
        test_drain_pause();

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        test_random(60);

        // let the last beats out, then a few quiet cycles
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_results.size() != 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> text_tokenizer_quotes_comments_unit.f
design/ttqc_pkg.sv
design/ttqc_parser.sv
design/text_tokenizer_quotes_comments_unit.sv
dv/testbench.sv
